// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level of the DNS query message builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DQMB_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("DQMB assertion failed");
`define DQMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("DQMB assertion failed");
`else
`define DQMB_ASSERT(lbl, expr)
`define DQMB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/dqmb_pkg.sv -----
// Types and constants of the DNS query message builder.
package dqmb_pkg;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_CHAR   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_NAME_LONG   = 2'd1;
  localparam logic [1:0] ERR_LABEL_LONG  = 2'd2;
  localparam logic [1:0] ERR_EMPTY_LABEL = 2'd3;

  localparam logic [7:0]  DOT_CHAR = 8'h2E;
  localparam logic [15:0] CLASS_IN = 16'h0001;
  localparam logic [15:0] QD_COUNT = 16'h0001;

  localparam int SEQ_IDX_W = 6;
  localparam logic [SEQ_IDX_W-1:0] HDR_LAST_IDX = 6'd11;
  localparam logic [SEQ_IDX_W-1:0] FIN_LAST_IDX = 6'd4;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int CMD_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_LABEL,
    CMD_ERR,
    CMD_FIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] data;
    logic [3:0]  op;
    logic        rd;
    logic        bank;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] query_id;
    logic [3:0]  op_code;
    logic        recursion_desired;
    logic [15:0] query_type;
    logic [7:0]  name_char;
    logic        is_last_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] error_code;
  } out_word_t;

endpackage

// ----- hdl/dns_query_message_builder.sv -----
// Top level of the DNS query message builder.
//
//   Channel  Handshake          Word         Moves
//   input    push / full        in_data      start, name character or finish item
//   result   pop / empty        out_data     one message byte or error result
//
// An item is taken at any edge where full is low and yields its bytes at one per cycle
// while pop keeps up: 12 for a start, label length plus one for a label flush, 5 for a finish,
// 1 for an error. Each command is loaded in an idle state, and its first byte passes the
// command queue, command register, sequencer stage and output register. full is high while
// the two-entry queue is full or the bank being filled holds an unread label. Reset clears
// control state, not memory. A stalled pop holds the output register and backs up the queue.
`include "assert_macros.svh"

module dns_query_message_builder
  import dqmb_pkg::*;
#(
  parameter int MAX_NAME_INDEX = 255,
  parameter int MAX_LABEL_LEN  = 63
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_word_t  in_data,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_data
);

  localparam int AW = (MAX_LABEL_LEN > 1) ? $clog2(MAX_LABEL_LEN) : 1;

  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t          cmd_in, cmd_out;
  bank_release_t bank_release;
  logic          wr_en, wr_bank, rd_en, rd_bank;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  dqmb_front #(
    .MAX_NAME_INDEX(MAX_NAME_INDEX),
    .MAX_LABEL_LEN (MAX_LABEL_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full),
    .release_in(bank_release),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  dqmb_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .push_cmd(cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .pop_cmd (cmd_out),
    .empty   (cmd_empty)
  );

  dqmb_label_mem #(
    .MAX_LABEL_LEN(MAX_LABEL_LEN)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_bank(wr_bank),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_bank(rd_bank),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  dqmb_back #(
    .MAX_LABEL_LEN(MAX_LABEL_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .rd_en      (rd_en),
    .rd_bank    (rd_bank),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .release_out(bank_release),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

  `DQMB_ASSERT(a_no_push_into_full, !(cmd_push && cmd_full))
  `DQMB_ASSERT(a_error_is_last, empty || out_data.error_code == ERR_NONE || out_data.last)
  `DQMB_ASSERT(a_error_byte_zero, empty || out_data.error_code == ERR_NONE || out_data.out_byte == 8'h00)
  `DQMB_ASSERT_NEXT(a_cmd_enqueued, cmd_push && !cmd_pop, !cmd_empty)

endmodule

// ----- hdl/dqmb_label_mem.sv -----
// Two-bank label byte memory with one write port and one registered read port.
module dqmb_label_mem #(
  parameter int MAX_LABEL_LEN = 63,
  localparam int AW = (MAX_LABEL_LEN > 1) ? $clog2(MAX_LABEL_LEN) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          wr_bank,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic          rd_bank,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem_r [2][MAX_LABEL_LEN];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_bank][wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_bank][rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/dqmb_cmd_fifo.sv -----
// Short command queue between the item classifier and the byte sequencer.
module dqmb_cmd_fifo
  import dqmb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hdl/dqmb_front.sv -----
// Item classifier: tracks name and label state, buffers label bytes, queues commands.
module dqmb_front
  import dqmb_pkg::*;
#(
  parameter int MAX_NAME_INDEX = 255,
  parameter int MAX_LABEL_LEN  = 63,
  localparam int AW = (MAX_LABEL_LEN > 1) ? $clog2(MAX_LABEL_LEN) : 1,
  localparam int CW = $clog2(MAX_LABEL_LEN + 1),
  localparam int PW = $clog2(MAX_NAME_INDEX + 2)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  in_word_t      in_data,
  output logic          full,
  output logic          cmd_push,
  output cmd_t          cmd,
  input  logic          cmd_full,
  input  bank_release_t release_in,
  output logic          wr_en,
  output logic          wr_bank,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          ovf_r, ovf_nxt;
  logic          failed_r, failed_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;
  logic          accept;
  logic          is_dot;

  assign full    = cmd_full || busy_r[bank_r];
  assign accept  = push && !full;
  assign is_dot  = (in_data.name_char == DOT_CHAR);
  assign wr_bank = bank_r;
  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = in_data.name_char;

  always_comb begin
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    ovf_nxt    = ovf_r;
    failed_nxt = failed_r;
    bank_nxt   = bank_r;
    busy_nxt   = busy_r;
    cmd_push   = 1'b0;
    cmd        = '0;
    wr_en      = 1'b0;
    if (release_in.valid) begin
      busy_nxt[release_in.bank] = 1'b0;
    end
    if (accept) begin
      unique case (in_data.mode)
        MODE_START: begin
          cnt_nxt    = '0;
          pos_nxt    = '0;
          ovf_nxt    = 1'b0;
          failed_nxt = 1'b0;
          cmd_push   = 1'b1;
          cmd.kind   = CMD_HDR;
          cmd.data   = in_data.query_id;
          cmd.op     = in_data.op_code;
          cmd.rd     = in_data.recursion_desired;
        end
        MODE_CHAR: begin
          if (!failed_r) begin
            if (pos_r > PW'(MAX_NAME_INDEX)) begin
              failed_nxt = 1'b1;
              cmd_push   = 1'b1;
              cmd.kind   = CMD_ERR;
              cmd.data   = 16'(ERR_NAME_LONG);
            end else if (is_dot && in_data.is_last_char && pos_r == '0) begin
              pos_nxt = PW'(1);
            end else begin
              pos_nxt = pos_r + 1'b1;
              if (!is_dot) begin
                if (cnt_r < CW'(MAX_LABEL_LEN)) begin
                  wr_en   = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
              if (is_dot || in_data.is_last_char) begin
                cmd_push = 1'b1;
                if (ovf_nxt) begin
                  failed_nxt = 1'b1;
                  cmd.kind   = CMD_ERR;
                  cmd.data   = 16'(ERR_LABEL_LONG);
                end else if (cnt_nxt == '0) begin
                  failed_nxt = 1'b1;
                  cmd.kind   = CMD_ERR;
                  cmd.data   = 16'(ERR_EMPTY_LABEL);
                end else begin
                  cmd.kind         = CMD_LABEL;
                  cmd.data         = 16'(cnt_nxt);
                  cmd.bank         = bank_r;
                  busy_nxt[bank_r] = 1'b1;
                  bank_nxt         = !bank_r;
                  cnt_nxt          = '0;
                end
              end
            end
          end
        end
        MODE_FINISH: begin
          if (!failed_r) begin
            cnt_nxt  = '0;
            pos_nxt  = '0;
            ovf_nxt  = 1'b0;
            cmd_push = 1'b1;
            cmd.kind = CMD_FIN;
            cmd.data = in_data.query_type;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pos_r    <= '0;
      ovf_r    <= 1'b0;
      failed_r <= 1'b0;
      bank_r   <= 1'b0;
      busy_r   <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      ovf_r    <= ovf_nxt;
      failed_r <= failed_nxt;
      bank_r   <= bank_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

// ----- hdl/dqmb_back.sv -----
// Byte sequencer: expands queued commands into message bytes behind an output register.
module dqmb_back
  import dqmb_pkg::*;
#(
  parameter int MAX_LABEL_LEN = 63,
  localparam int AW = (MAX_LABEL_LEN > 1) ? $clog2(MAX_LABEL_LEN) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  cmd_t          cmd,
  output logic          cmd_pop,
  output logic          rd_en,
  output logic          rd_bank,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output bank_release_t release_out,
  output logic          empty,
  input  logic          pop,
  output out_word_t     out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t               state_r;
  cmd_t                 cmd_r;
  logic [SEQ_IDX_W-1:0] idx_r;
  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_last_r;
  logic [1:0]           s1_err_r;
  logic                 s1_mem_r;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  logic                 move_out, s1_free, issue;
  logic                 seq_final, seq_mem;
  logic [7:0]           seq_byte;
  logic [1:0]           seq_err;
  logic [SEQ_IDX_W-1:0] rd_idx;

  assign move_out = s1_valid_r && (!out_valid_r || pop);
  assign s1_free  = !s1_valid_r || move_out;
  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;
  assign issue    = (state_r == ST_RUN) && s1_free;
  assign rd_idx   = idx_r - 1'b1;

  always_comb begin
    seq_final = 1'b0;
    seq_mem   = 1'b0;
    seq_byte  = 8'h00;
    seq_err   = ERR_NONE;
    unique case (cmd_r.kind)
      CMD_HDR: begin
        seq_final = (idx_r == HDR_LAST_IDX);
        unique case (idx_r)
          6'd0:    seq_byte = cmd_r.data[15:8];
          6'd1:    seq_byte = cmd_r.data[7:0];
          6'd2:    seq_byte = {1'b0, cmd_r.op, 2'b00, cmd_r.rd};
          6'd4:    seq_byte = QD_COUNT[15:8];
          6'd5:    seq_byte = QD_COUNT[7:0];
          default: seq_byte = 8'h00;
        endcase
      end
      CMD_LABEL: begin
        seq_final = (idx_r == cmd_r.data[SEQ_IDX_W-1:0]);
        seq_mem   = (idx_r != '0);
        seq_byte  = cmd_r.data[7:0];
      end
      CMD_ERR: begin
        seq_final = 1'b1;
        seq_err   = cmd_r.data[1:0];
      end
      CMD_FIN: begin
        seq_final = (idx_r == FIN_LAST_IDX);
        unique case (idx_r)
          6'd1:    seq_byte = cmd_r.data[15:8];
          6'd2:    seq_byte = cmd_r.data[7:0];
          6'd3:    seq_byte = CLASS_IN[15:8];
          6'd4:    seq_byte = CLASS_IN[7:0];
          default: seq_byte = 8'h00;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign rd_en             = issue && seq_mem;
  assign rd_bank           = cmd_r.bank;
  assign rd_addr           = rd_idx[AW-1:0];
  assign release_out.valid = issue && seq_final && (cmd_r.kind == CMD_LABEL);
  assign release_out.bank  = cmd_r.bank;
  assign empty             = !out_valid_r;
  assign out_data          = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue && seq_final) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (move_out) begin
        s1_valid_r <= 1'b0;
      end
      if (move_out) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd_pop) begin
      cmd_r <= cmd;
      idx_r <= '0;
    end else if (issue) begin
      idx_r <= idx_r + 1'b1;
    end
    if (issue) begin
      s1_byte_r <= seq_byte;
      s1_last_r <= seq_final;
      s1_err_r  <= seq_err;
      s1_mem_r  <= seq_mem;
    end
    if (move_out) begin
      out_data_r.out_byte   <= s1_mem_r ? rd_data : s1_byte_r;
      out_data_r.last       <= s1_last_r;
      out_data_r.error_code <= s1_err_r;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the DNS query message builder byte stream.
`timescale 1ns / 1ps

module tb;
  import dqmb_pkg::*;

  localparam int NAME_IDX_MAX = 255;
  localparam int LABEL_LEN_MAX = 63;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 8;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam int MSG_NORMAL = 0;
  localparam int MSG_LONG_LABEL = 1;
  localparam int MSG_NOISE = 3;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic empty;
  logic pop;
  in_word_t in_data;
  out_word_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  class query_msg_tracker;
    out_word_t due_bytes[$];
    logic [7:0] label_bytes[0:LABEL_LEN_MAX-1];
    int unsigned label_len;
    int unsigned name_pos;
    bit label_over;
    bit msg_failed;
    int errors;

    function new();
      clear_name();
      msg_failed = 1'b0;
      errors = 0;
    endfunction

    function void clear_name();
      label_len = 0;
      name_pos = 0;
      label_over = 1'b0;
    endfunction

    function void add_byte(logic [7:0] b);
      out_word_t w;
      w.out_byte = b;
      w.last = 1'b0;
      w.error_code = ERR_NONE;
      due_bytes.push_back(w);
    endfunction

    function void raise_error(logic [1:0] code);
      out_word_t w;
      msg_failed = 1'b1;
      w.out_byte = 8'h00;
      w.last = 1'b0;
      w.error_code = code;
      due_bytes.push_back(w);
    endfunction

    function int pending();
      return due_bytes.size();
    endfunction

    function void note_item(in_word_t w);
      int unsigned first_idx;
      int unsigned i;
      bit is_dot;
      out_word_t tail;
      first_idx = due_bytes.size();
      is_dot = (w.name_char == DOT_CHAR);
      case (w.mode)
        MODE_START: begin
          clear_name();
          msg_failed = 1'b0;
          add_byte(w.query_id[15:8]);
          add_byte(w.query_id[7:0]);
          add_byte({1'b0, w.op_code, 2'b00, w.recursion_desired});
          add_byte(8'h00);
          add_byte(QD_COUNT[15:8]);
          add_byte(QD_COUNT[7:0]);
          repeat (6) add_byte(8'h00);
        end
        MODE_CHAR: begin
          if (!msg_failed) begin
            if (name_pos > NAME_IDX_MAX) begin
              raise_error(ERR_NAME_LONG);
            end else if (is_dot && w.is_last_char && name_pos == 0) begin
              name_pos = 1;
            end else begin
              name_pos++;
              if (!is_dot) begin
                if (label_len < LABEL_LEN_MAX) begin
                  label_bytes[label_len] = w.name_char;
                  label_len++;
                end else begin
                  label_over = 1'b1;
                end
              end
              if (is_dot || w.is_last_char) begin
                if (label_over) begin
                  raise_error(ERR_LABEL_LONG);
                end else if (label_len == 0) begin
                  raise_error(ERR_EMPTY_LABEL);
                end else begin
                  add_byte(8'(label_len));
                  for (i = 0; i < label_len; i++) add_byte(label_bytes[i]);
                  label_len = 0;
                end
              end
            end
          end
        end
        MODE_FINISH: begin
          if (!msg_failed) begin
            clear_name();
            add_byte(8'h00);
            add_byte(w.query_type[15:8]);
            add_byte(w.query_type[7:0]);
            add_byte(CLASS_IN[15:8]);
            add_byte(CLASS_IN[7:0]);
          end
        end
        default: ;
      endcase
      if (due_bytes.size() > first_idx) begin
        tail = due_bytes.pop_back();
        tail.last = 1'b1;
        due_bytes.push_back(tail);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (due_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: byte %h last %b error %0d", $time,
                 got.out_byte, got.last, got.error_code);
        return;
      end
      want = due_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte expected %h, got %h", $time, want.out_byte, got.out_byte);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %b, got %b", $time, want.last, got.last);
      end
      if (got.error_code !== want.error_code) begin
        errors++;
        $display("%0t: error_code expected %0d, got %0d", $time, want.error_code,
                 got.error_code);
      end
    endfunction
  endclass

  query_msg_tracker tracker;

  dns_query_message_builder #(
    .MAX_NAME_INDEX(NAME_IDX_MAX),
    .MAX_LABEL_LEN (LABEL_LEN_MAX)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) tracker.check_word(out_data);
  end

  function automatic in_word_t noise_word();
    in_word_t w;
    w.mode = 2'($urandom_range(0, 3));
    w.query_id = 16'($urandom);
    w.op_code = 4'($urandom);
    w.recursion_desired = 1'($urandom);
    w.query_type = 16'($urandom);
    w.name_char = 8'($urandom);
    w.is_last_char = 1'($urandom);
    return w;
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      do c = 8'($urandom); while (c == DOT_CHAR);
    end else begin
      c = 8'($urandom_range(8'h61, 8'h7A));
    end
    return c;
  endfunction

  task automatic push_word(in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
    tracker.note_item(w);
    if (w.mode != MODE_IGNORED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_start(logic [15:0] id, logic [3:0] op, logic rd);
    in_word_t w;
    w = noise_word();
    w.mode = MODE_START;
    w.query_id = id;
    w.op_code = op;
    w.recursion_desired = rd;
    push_word(w);
  endtask

  task automatic send_char(logic [7:0] c, logic is_last);
    in_word_t w;
    w = noise_word();
    w.mode = MODE_CHAR;
    w.name_char = c;
    w.is_last_char = is_last;
    push_word(w);
  endtask

  task automatic send_finish(logic [15:0] qt);
    in_word_t w;
    w = noise_word();
    w.mode = MODE_FINISH;
    w.query_type = qt;
    push_word(w);
  endtask

  task automatic send_ignored();
    in_word_t w;
    w = noise_word();
    w.mode = MODE_IGNORED;
    push_word(w);
  endtask

  task automatic send_label(int len, logic mark_last);
    int k;
    for (k = 0; k < len; k++) send_char(rand_char(), mark_last && (k == len - 1));
  endtask

  task automatic send_message(int style);
    int len;
    int nlab;
    int ending;
    int k;
    send_start(16'($urandom), 4'($urandom), 1'($urandom));
    case (style)
      MSG_LONG_LABEL: send_label($urandom_range(64, 66), 1'b1);
      MSG_NOISE: repeat ($urandom_range(3, 8)) push_word(noise_word());
      default: begin
        nlab = $urandom_range(1, 4);
        ending = $urandom_range(0, 9);
        if (ending == 0) begin
          send_char(DOT_CHAR, 1'b1);
        end else begin
          for (k = 0; k < nlab; k++) begin
            if ($urandom_range(0, 19) == 0) len = LABEL_LEN_MAX;
            else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, LABEL_LEN_MAX);
            else len = $urandom_range(1, 8);
            if (k < nlab - 1) begin
              send_label(len, 1'b0);
              send_char(DOT_CHAR, 1'b0);
              if ($urandom_range(0, 14) == 0) send_char(DOT_CHAR, 1'b0);
            end else if (ending == 1) begin
              send_label(len, 1'b0);
              send_char(DOT_CHAR, 1'b1);
            end else if (ending == 2) begin
              send_label(len, 1'b0);
            end else begin
              send_label(len, 1'b1);
            end
          end
        end
        if ($urandom_range(0, 9) == 0) send_ignored();
      end
    endcase
    if ($urandom_range(0, 9) != 0) send_finish(16'($urandom));
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        hold_done = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int phase;
    int unsigned phase_start;
    tracker = new();
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 33 : 0;
      if (phase == 0) begin
        send_start(16'hFFFF, 4'hF, 1'b1);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(DOT_CHAR, 1'b0);
        send_char(8'hFF, 1'b1);
        send_finish(16'hFFFF);
        send_start(16'h0000, 4'h0, 1'b0);
        send_char(DOT_CHAR, 1'b1);
        send_finish(16'h0000);
        send_start(16'h1234, 4'h5, 1'b0);
        send_char(8'h78, 1'b0);
        send_char(DOT_CHAR, 1'b1);
        send_finish(16'h001C);
        send_start(16'hA5C3, 4'h2, 1'b1);
        send_char(DOT_CHAR, 1'b0);
        send_char(8'h79, 1'b1);
        send_finish(16'h0001);
        send_start(16'h0F0F, 4'h9, 1'b0);
        send_char(8'h71, 1'b0);
        send_finish(16'h00FF);
        send_start(16'h8001, 4'h1, 1'b1);
        send_char(8'h63, 1'b1);
        send_char(8'h00, 1'b1);
        send_finish(16'h0102);
        send_ignored();
        send_message(MSG_LONG_LABEL);
      end else if (phase == 2) begin
        hold_req = 1'b1;
        send_start(16'h5A5A, 4'h0, 1'b1);
        send_char(8'h61, 1'b1);
        send_finish(16'h0001);
        send_start(16'hC3C3, 4'h3, 1'b0);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS)
        send_message(($urandom_range(0, 9) == 0) ? MSG_NOISE : MSG_NORMAL);
      push <= 1'b0;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
